// ----- rtl/core/wpp_pkg.sv -----
// Package for the WAV PCM stream parser: result kinds, header offsets, tags
// and the event record passed from the parser to the output stage.
// No dependencies.
package wpp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FRAME       = 2'd0,
    KIND_BAD_TAG     = 2'd1,
    KIND_STRIDE_ZERO = 2'd2
  } kind_e;

  // Canonical header layout
  localparam int unsigned HeaderLen = 44;
  localparam int unsigned PosW      = 6;
  localparam logic [PosW-1:0] PosRiffEnd  = 6'd3;
  localparam logic [PosW-1:0] PosWaveEnd  = 6'd11;
  localparam logic [PosW-1:0] PosFmtEnd   = 6'd15;
  localparam logic [PosW-1:0] PosChanLo   = 6'd22;
  localparam logic [PosW-1:0] PosChanHi   = 6'd23;
  localparam logic [PosW-1:0] PosBitsLo   = 6'd34;
  localparam logic [PosW-1:0] PosBitsHi   = 6'd35;
  localparam logic [PosW-1:0] PosStride   = 6'd36;
  localparam logic [PosW-1:0] PosDataEnd  = 6'd39;
  localparam logic [PosW-1:0] PosSize0    = 6'd40;
  localparam logic [PosW-1:0] PosSize1    = 6'd41;
  localparam logic [PosW-1:0] PosSize2    = 6'd42;
  localparam logic [PosW-1:0] PosSize3    = 6'd43;
  localparam logic [PosW-1:0] PosHdrDone  = 6'(HeaderLen);

  // Tags, big-endian as they appear in the byte stream
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Bytes per sample (13 bits) times channel count (16 bits)
  localparam int unsigned StrideW = 29;

  // Event from the parser towards the output register
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] head;   // first four bytes of the frame
    logic        sb8;    // 8-bit unsigned samples
    logic        sb16;   // 16-bit signed samples
    logic        mono;
    logic        last;
  } evt_t;

endpackage

// ----- rtl/core/wpp_if.sv -----
// Handshake interfaces for the WAV PCM stream parser: input byte channel
// and result channel. No dependencies.
interface wpp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;

  modport source (output valid, output byte_value, output first_byte, input ready);
  modport sink   (input valid, input byte_value, input first_byte, output ready);
endinterface

interface wpp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               last_frame;

  modport source (output valid, output kind, output left_sample, output right_sample,
                  output last_frame, input ready);
  modport sink   (input valid, input kind, input left_sample, input right_sample,
                  input last_frame, output ready);
endinterface

// ----- rtl/core/wpp_parse.sv -----
// Header walker and data framer: tracks the header position, checks tags,
// captures the format fields and cuts the data chunk into frames.
// Depends on wpp_pkg.
module wpp_parse import wpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_value_i,
  input  logic       first_byte_i,
  output evt_t       evt_o
);

  logic [PosW-1:0]    pos_q, pos_d, cur_pos;
  logic [23:0]        tag_q, tag_d;
  logic [15:0]        chan_q, chan_d;
  logic [15:0]        bits_q, bits_d;
  logic [31:0]        size_q, size_d;
  logic [31:0]        seen_q, seen_d, cur_seen;
  logic [StrideW-1:0] offs_q, offs_d, cur_offs, offs_inc;
  logic [31:0]        head_q, head_d, cur_head;
  logic               stop_q, stop_d, cur_stop;
  logic [StrideW-1:0] stride_q, stride_d;
  logic [31:0]        tag_full;
  logic [31:0]        remain;
  logic               bad_tag;

  // A first byte restarts the file: the run-time state reads as cleared
  assign cur_pos  = first_byte_i ? '0 : pos_q;
  assign cur_stop = first_byte_i ? 1'b0 : stop_q;
  assign cur_seen = first_byte_i ? '0 : seen_q;
  assign cur_offs = first_byte_i ? '0 : offs_q;
  assign cur_head = first_byte_i ? '0 : head_q;

  assign tag_full = {tag_q, byte_value_i};
  assign offs_inc = cur_offs + 1'b1;
  // Data bytes left once this byte is counted
  assign remain   = size_q - cur_seen - 32'd1;

  assign bad_tag = (cur_pos == PosRiffEnd && tag_full != TagRiff) ||
                   (cur_pos == PosWaveEnd && tag_full != TagWave) ||
                   (cur_pos == PosFmtEnd  && tag_full != TagFmt)  ||
                   (cur_pos == PosDataEnd && tag_full != TagData);

  // Next state and event
  always_comb begin
    pos_d    = cur_pos;
    tag_d    = tag_q;
    chan_d   = chan_q;
    bits_d   = bits_q;
    size_d   = size_q;
    seen_d   = cur_seen;
    offs_d   = cur_offs;
    head_d   = cur_head;
    stop_d   = cur_stop;
    stride_d = stride_q;

    evt_o       = '0;
    evt_o.kind  = KIND_FRAME;
    evt_o.sb8   = (bits_q == 16'd8);
    evt_o.sb16  = (bits_q == 16'd16);
    evt_o.mono  = (chan_q == 16'd1);

    if (!cur_stop) begin
      if (cur_pos < PosHdrDone) begin
        // Header byte
        pos_d = cur_pos + 1'b1;
        tag_d = tag_full[23:0];
        case (cur_pos)
          PosChanLo: chan_d[7:0]   = byte_value_i;
          PosChanHi: chan_d[15:8]  = byte_value_i;
          PosBitsLo: bits_d[7:0]   = byte_value_i;
          PosBitsHi: bits_d[15:8]  = byte_value_i;
          PosStride: stride_d      = StrideW'(bits_q[15:3] * chan_q);
          PosSize0:  size_d[7:0]   = byte_value_i;
          PosSize1:  size_d[15:8]  = byte_value_i;
          PosSize2:  size_d[23:16] = byte_value_i;
          PosSize3:  size_d[31:24] = byte_value_i;
          default:   ;
        endcase
        if (bad_tag) begin
          stop_d      = 1'b1;
          evt_o.valid = 1'b1;
          evt_o.kind  = KIND_BAD_TAG;
          evt_o.sb8   = 1'b0;
          evt_o.sb16  = 1'b0;
        end else if (cur_pos == PosSize3 && stride_q == '0) begin
          stop_d      = 1'b1;
          evt_o.valid = 1'b1;
          evt_o.kind  = KIND_STRIDE_ZERO;
          evt_o.sb8   = 1'b0;
          evt_o.sb16  = 1'b0;
        end
      end else if (cur_seen < size_q && stride_q != '0) begin
        // Data byte
        seen_d = cur_seen + 1'b1;
        if (cur_offs < StrideW'(4)) begin
          case (cur_offs[1:0])
            2'd0:    head_d[7:0]   = byte_value_i;
            2'd1:    head_d[15:8]  = byte_value_i;
            2'd2:    head_d[23:16] = byte_value_i;
            default: head_d[31:24] = byte_value_i;
          endcase
        end
        if (offs_inc == stride_q) begin
          offs_d      = '0;
          evt_o.valid = 1'b1;
          evt_o.last  = (remain < {3'b000, stride_q});
        end else begin
          offs_d = offs_inc;
        end
      end
    end

    // Frame head including the byte taken now
    evt_o.head = head_d;
  end

  // State registers, loaded on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      tag_q    <= '0;
      chan_q   <= '0;
      bits_q   <= '0;
      size_q   <= '0;
      seen_q   <= '0;
      offs_q   <= '0;
      head_q   <= '0;
      stop_q   <= 1'b0;
      stride_q <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      tag_q    <= tag_d;
      chan_q   <= chan_d;
      bits_q   <= bits_d;
      size_q   <= size_d;
      seen_q   <= seen_d;
      offs_q   <= offs_d;
      head_q   <= head_d;
      stop_q   <= stop_d;
      stride_q <= stride_d;
    end
  end

endmodule

// ----- rtl/core/wpp_out.sv -----
// Sample conversion to Q1.15 and the result register with its handshake.
// Depends on wpp_pkg and wpp_result_if.
module wpp_out import wpp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  evt_t  evt_i,
  output logic  load_ok_o,
  wpp_result_if.source result_o
);

  logic               valid_q;
  logic [1:0]         kind_q;
  logic signed [15:0] left_q, left_d;
  logic signed [15:0] right_q, right_d;
  logic               last_q;
  logic [15:0]        s8_lo, s8_hi;

  // Result register may take a new item when empty or being drained
  assign load_ok_o = !valid_q || result_o.ready;

  // 8-bit unsigned to Q1.15: flip the sign bit, scale by 256
  assign s8_lo = {evt_i.head[7] ^ 1'b1, evt_i.head[6:0], 8'h00};
  assign s8_hi = {evt_i.head[15] ^ 1'b1, evt_i.head[14:8], 8'h00};

  always_comb begin
    left_d  = '0;
    right_d = '0;
    if (evt_i.sb8) begin
      left_d  = s8_lo;
      right_d = s8_hi;
    end else if (evt_i.sb16) begin
      left_d  = evt_i.head[15:0];
      right_d = evt_i.head[31:16];
    end
    if (evt_i.mono) right_d = left_d;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= fire_i && evt_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_ok_o && fire_i && evt_i.valid) begin
      kind_q  <= evt_i.kind;
      left_q  <= left_d;
      right_q <= right_d;
      last_q  <= evt_i.last;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.kind         = kind_q;
  assign result_o.left_sample  = left_q;
  assign result_o.right_sample = right_q;
  assign result_o.last_frame   = last_q;

endmodule

// ----- rtl/core/wav_pcm_stream_parser.sv -----
// Channel   | Dir | Payload                                        | Accepted when
// item_i    | in  | byte_value[7:0], first_byte                    | valid && ready
// result_o  | out | kind[1:0], left/right_sample[15:0], last_frame | valid && ready
//
// One byte per cycle while ready; a result shows in the cycle after its byte.
// The per-byte cost is one counter step and a shift into the tag register; the
// frame stride product is formed once, at header byte 36.
// Reset clears all parser state; first_byte restarts parsing on the same byte.
// item_i.ready drops only while a result is held and result_o.ready is low.
//
// Top level of the WAV PCM stream parser. Depends on wpp_pkg, wpp_if,
// wpp_parse and wpp_out.
module wav_pcm_stream_parser import wpp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  wpp_item_if.sink     item_i,
  wpp_result_if.source result_o
);

  logic fire;
  logic load_ok;
  evt_t evt;

  assign item_i.ready = load_ok;
  assign fire         = item_i.valid && load_ok;

  // Header and data parsing
  wpp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_value_i (item_i.byte_value),
    .first_byte_i (item_i.first_byte),
    .evt_o        (evt)
  );

  // Conversion and result register
  wpp_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .evt_i     (evt),
    .load_ok_o (load_ok),
    .result_o  (result_o)
  );

endmodule

// ----- tb/tb_wav_pcm_stream_parser.sv -----
// Self-checking testbench for wav_pcm_stream_parser: feeds WAV byte streams
// and checks every result item against a local parser model or a directed table.
// Depends on wpp_pkg, wpp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_wav_pcm_stream_parser;
  import wpp_pkg::*;

  localparam int ItemTarget = 1950;
  localparam int CycleLimit = 400000;

  // One decoded result item
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } wav_result_t;

  // Row of the directed byte table; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0] value;
    logic       first;
    bit         typed;
    bit         has_res;
    kind_e      kind;
  } byte_row_t;

  // Shapes of generated files
  typedef enum int {
    CASE_PCM,
    CASE_BAD_TAG,
    CASE_NO_STRIDE,
    CASE_CUT_SHORT,
    CASE_WIDE,
    CASE_NOISE
  } wav_case_e;

  localparam byte_row_t DirRows [25] = '{
    // straight after reset, no first_byte: header starts here
    '{8'h52, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h49, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'h7F, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'h57, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'h41, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    '{8'h56, 1'b0, 1'b0, 1'b0, KIND_FRAME},
    // "WAVX": bad tag, then parsing stops
    '{8'h58, 1'b0, 1'b1, 1'b1, KIND_BAD_TAG},
    '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    // restart on a wrong first byte
    '{8'h00, 1'b1, 1'b1, 1'b0, KIND_FRAME},
    '{8'h49, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b1, KIND_BAD_TAG},
    // all-ones header start
    '{8'hFF, 1'b1, 1'b1, 1'b0, KIND_FRAME},
    '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'hFF, 1'b0, 1'b1, 1'b1, KIND_BAD_TAG},
    // good tag after a restart
    '{8'h52, 1'b1, 1'b1, 1'b0, KIND_FRAME},
    '{8'h49, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b0, KIND_FRAME},
    '{8'h46, 1'b0, 1'b1, 1'b0, KIND_FRAME}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wpp_item_if   item_if ();
  wpp_result_if res_if ();

  wav_pcm_stream_parser i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if)
  );

  // Clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Parser model state
  logic [5:0]  hdr_pos;
  logic [31:0] tag_sr;
  logic [15:0] n_chan;
  logic [15:0] n_bits;
  logic [31:0] data_len;
  logic [31:0] data_cnt;
  logic [31:0] frame_idx;
  logic [31:0] frame_head;
  logic        stopped;

  wav_result_t due_results [$];
  logic [7:0]  file_bytes [$];
  int          parsed_bytes = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;

  function automatic void clear_parser();
    hdr_pos    = '0;
    tag_sr     = '0;
    n_chan     = '0;
    n_bits     = '0;
    data_len   = '0;
    data_cnt   = '0;
    frame_idx  = '0;
    frame_head = '0;
    stopped    = 1'b0;
  endfunction

  // Q1.15 sample from the frame head, starting at byte i
  function automatic logic [15:0] frame_sample(input int i);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = frame_head[8*(i % 4) +: 8];
    hi = frame_head[8*((i + 1) % 4) +: 8];
    if (n_bits == 16'd8) return {lo ^ 8'h80, 8'h00};
    if (n_bits == 16'd16) return {hi, lo};
    return '0;
  endfunction

  // Advance the model by one byte; returns 1 when a result item is due
  function automatic bit parse_wav_byte(input logic [7:0] b, input logic first,
                                        output wav_result_t res, output bit used);
    logic [5:0]  pos;
    logic [31:0] stride;
    bit          bad;
    res  = '0;
    used = 1'b0;
    if (first) clear_parser();
    if (stopped) return 1'b0;
    stride = 32'(n_bits >> 3) * 32'(n_chan);

    // header bytes
    if (hdr_pos < HeaderLen) begin
      used    = 1'b1;
      pos     = hdr_pos;
      hdr_pos = pos + 6'd1;
      tag_sr  = {tag_sr[23:0], b};
      if (pos == PosChanLo) n_chan[7:0] = b;
      if (pos == PosChanHi) n_chan[15:8] = b;
      if (pos == PosBitsLo) n_bits[7:0] = b;
      if (pos == PosBitsHi) n_bits[15:8] = b;
      if (pos >= PosSize0) data_len[8*(pos - PosSize0) +: 8] = b;
      bad = (pos == PosRiffEnd && tag_sr != TagRiff) ||
            (pos == PosWaveEnd && tag_sr != TagWave) ||
            (pos == PosFmtEnd && tag_sr != TagFmt) ||
            (pos == PosDataEnd && tag_sr != TagData);
      if (bad) begin
        stopped  = 1'b1;
        res.kind = KIND_BAD_TAG;
        return 1'b1;
      end
      stride = 32'(n_bits >> 3) * 32'(n_chan);
      if (pos == PosSize3 && stride == 0) begin
        stopped  = 1'b1;
        res.kind = KIND_STRIDE_ZERO;
        return 1'b1;
      end
      return 1'b0;
    end

    // data bytes; anything past the chunk is ignored
    if (data_cnt >= data_len || stride == 0) return 1'b0;
    used     = 1'b1;
    data_cnt = data_cnt + 1;
    if (frame_idx < 4) frame_head[8*frame_idx[1:0] +: 8] = b;
    frame_idx = frame_idx + 1;
    if (frame_idx < stride) return 1'b0;
    frame_idx = '0;
    res.kind  = KIND_FRAME;
    res.left  = frame_sample(0);
    res.right = (n_chan == 16'd1) ? res.left : frame_sample(n_bits == 16'd16 ? 2 : 1);
    res.last  = (data_len - data_cnt) < stride;
    return 1'b1;
  endfunction

  // Offer one byte, wait for acceptance, then run the model on it
  task automatic send_byte(input logic [7:0] b, input logic f,
                           output bit got, output wav_result_t res, output bit used);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.byte_value <= b;
    item_if.first_byte <= f;
    do @(posedge clk_i); while (!item_if.ready);
    got = parse_wav_byte(b, f, res, used);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic f);
    bit          got;
    bit          used;
    wav_result_t res;
    send_byte(b, f, got, res, used);
    if (got) due_results.push_back(res);
    if (used) parsed_bytes++;
  endtask

  function automatic void add_field(input logic [31:0] v, input int n, input bit msb_first);
    for (int k = 0; k < n; k++)
      file_bytes.push_back(msb_first ? v[8*(n-1-k) +: 8] : v[8*k +: 8]);
  endfunction

  // Build one file of the given shape and stream it
  task automatic send_wav(input wav_case_e shape, input bit plain);
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] size;
    logic [31:0] stride;
    int          frames;
    int          extra;
    int          n_data;
    int          spot;
    chans = 16'($urandom_range(1, 4));
    if ($urandom_range(7) == 0) chans = 16'($urandom_range(5, 6));
    case ($urandom_range(9))
      0:       bits = 16'd24;
      1:       bits = 16'd32;
      2:       bits = 16'd12;
      3, 4, 5: bits = 16'd8;
      default: bits = 16'd16;
    endcase
    if (plain) begin
      chans = 16'd1;
      bits  = 16'd8;
    end
    if (shape == CASE_NO_STRIDE) begin
      if ($urandom_range(1) == 1) chans = '0;
      else bits = 16'($urandom_range(0, 7));
    end
    if (shape == CASE_WIDE) begin
      chans = 16'($urandom);
      bits  = 16'($urandom);
    end
    stride = 32'(bits >> 3) * 32'(chans);
    frames = plain ? 24 : $urandom_range(0, 10);
    extra  = 0;
    if (shape != CASE_WIDE && stride > 1 && $urandom_range(2) == 0)
      extra = $urandom_range(1, stride - 1);
    size = (shape == CASE_WIDE) ? $urandom : 32'(frames) * stride + 32'(extra);

    // canonical header; unchecked fields get random content
    file_bytes.delete();
    add_field(TagRiff, 4, 1'b1);
    add_field($urandom, 4, 1'b0);
    add_field(TagWave, 4, 1'b1);
    add_field(TagFmt, 4, 1'b1);
    add_field($urandom, 4, 1'b0);
    add_field($urandom, 2, 1'b0);
    add_field(32'(chans), 2, 1'b0);
    add_field($urandom, 4, 1'b0);
    add_field($urandom, 4, 1'b0);
    add_field($urandom, 2, 1'b0);
    add_field(32'(bits), 2, 1'b0);
    add_field(TagData, 4, 1'b1);
    add_field(size, 4, 1'b0);

    // data chunk with a few trailing bytes; wide files are cut off early
    n_data = (shape == CASE_WIDE) ? $urandom_range(0, 40) : int'(size) + $urandom_range(0, 4);
    repeat (n_data) begin
      case ($urandom_range(7))
        0:       file_bytes.push_back(8'h00);
        1:       file_bytes.push_back(8'hFF);
        2:       file_bytes.push_back(8'h80);
        3:       file_bytes.push_back(8'h7F);
        default: file_bytes.push_back(8'($urandom));
      endcase
    end

    if (shape == CASE_BAD_TAG) begin
      case ($urandom_range(3))
        0:       spot = 0;
        1:       spot = 8;
        2:       spot = 12;
        default: spot = 36;
      endcase
      spot = spot + $urandom_range(3);
      file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
    end
    if (shape == CASE_CUT_SHORT) begin
      spot = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > spot) void'(file_bytes.pop_back());
    end
    if (shape == CASE_NOISE) begin
      file_bytes.delete();
      repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
    end

    foreach (file_bytes[i])
      feed_byte(file_bytes[i],
                shape == CASE_NOISE ? ($urandom_range(7) == 0) : (i == 0));
  endtask

  // Result side: random stalls plus a single long hold-off
  initial begin : result_drain
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic report(input string what, input int want_v, input int got_v);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    wav_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        report("unexpected result kind", -1, int'(res_if.kind));
      end else begin
        want = due_results.pop_front();
        if (res_if.kind != want.kind) report("kind", int'(want.kind), int'(res_if.kind));
        if (res_if.left_sample != want.left)
          report("left_sample", int'(want.left), int'(res_if.left_sample));
        if (res_if.right_sample != want.right)
          report("right_sample", int'(want.right), int'(res_if.right_sample));
        if (res_if.last_frame != want.last)
          report("last_frame", int'(want.last), int'(res_if.last_frame));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    bit          got;
    bit          used;
    wav_result_t res;
    wav_case_e   shape;
    int          phase;
    int          next_phase;
    int          file_no;
    int          pick;
    item_if.valid      = 1'b0;
    item_if.byte_value = '0;
    item_if.first_byte = 1'b0;
    res_if.ready       = 1'b0;
    clear_parser();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (DirRows[i]) begin
      send_byte(DirRows[i].value, DirRows[i].first, got, res, used);
      if (DirRows[i].typed) begin
        if (DirRows[i].has_res)
          due_results.push_back(wav_result_t'{DirRows[i].kind, 16'sd0, 16'sd0, 1'b0});
      end else if (got) begin
        due_results.push_back(res);
      end
    end

    // random files, idling profile changes by quarter
    phase   = 0;
    file_no = 0;
    while (parsed_bytes < ItemTarget) begin
      next_phase = (parsed_bytes * 4) / ItemTarget;
      if (next_phase != phase) begin
        @(negedge clk_i);
        item_if.valid <= 1'b0;
        while (due_results.size() != 0) @(negedge clk_i);
        phase = next_phase;
        case (phase)
          1: begin
            send_idle_pct = 65;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 65;
          end
          default: begin
            send_idle_pct = 13;
            stall_pct     = 13;
          end
        endcase
      end
      if (file_no < 6) begin
        shape = wav_case_e'(file_no);
      end else begin
        pick = $urandom_range(99);
        if (pick < 50)      shape = CASE_PCM;
        else if (pick < 62) shape = CASE_BAD_TAG;
        else if (pick < 72) shape = CASE_NO_STRIDE;
        else if (pick < 84) shape = CASE_CUT_SHORT;
        else if (pick < 92) shape = CASE_WIDE;
        else                shape = CASE_NOISE;
      end
      // first file runs against a long result hold-off to back up the input
      if (file_no == 0) hold_request = 300;
      send_wav(shape, file_no == 0);
      file_no++;
    end

    // drain and settle
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
